@@ rtl/core/assert_macros.svh @@
// assertion macros used by vector_metric_distance
// no dependencies; expects clk and arst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define VMD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define VMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/vmd_pkg.sv @@
// types and constants of the vector metric distance block
// no dependencies
package vmd_pkg;

	localparam int ELEM_W     = 16;
	localparam int ABS_W      = 16;
	localparam int TERM_W     = 32;
	localparam int ACC_W      = 41;
	localparam int DIST_W     = 24;
	localparam int ROOT_W     = (ACC_W + 1) / 2;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int REM_W      = ROOT_W + 2;
	localparam int STEP_W     = $clog2(ROOT_W);

	typedef enum logic [1:0] {
		METRIC_EUCLID = 2'd0,
		METRIC_MANHAT = 2'd1,
		METRIC_CHEBY  = 2'd2,
		METRIC_DISCR  = 2'd3
	} metric_t;

	typedef struct packed {
		logic [ACC_W-1:0] acc;
		metric_t          mode;
	} vmd_entry_t;

	typedef struct packed {
		logic busy;
		logic done;
	} vmd_sqrt_stat_t;

	typedef enum logic {
		BK_IDLE,
		BK_SQRT
	} back_state_t;

endpackage

@@ rtl/core/vector_metric_distance.sv @@
// Vector distance over streamed element pairs (euclidean, manhattan, chebyshev, discrete).
// Element pairs are taken at one per cycle for as long as the result queue has room; the
// front end folds each pair through a two stage pipeline (|x-y|, then the square for
// euclidean) into a 41 bit accumulator. On the item flagged last, the finished value goes
// into a queue of QDEPTH vectors. The back end turns it into a distance: manhattan,
// chebyshev and discrete results go straight to the output register, euclidean ones come
// from the 21 step bit-serial square root, which handles one vector at a time. Input stall
// rises only when QDEPTH finished vectors are waiting or in flight. metric_kind is written
// through the config channel, which is always ready, and applies from the next item.
// Depends on vmd_pkg, vmd_front, vmd_queue, vmd_back and assert_macros.svh.
`include "assert_macros.svh"

module vector_metric_distance #(
	parameter int QDEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [vmd_pkg::ELEM_W-1:0] x_elem,
	input  logic signed [vmd_pkg::ELEM_W-1:0] y_elem,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [vmd_pkg::DIST_W-1:0]        distance,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_data
);

	localparam int CNT_W = $clog2(QDEPTH + 1);

	vmd_pkg::metric_t    metric_kind_q;
	logic                q_push, q_pop;
	vmd_pkg::vmd_entry_t q_wr_entry, q_rd_entry;
	logic [CNT_W-1:0]    q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_kind_q <= vmd_pkg::METRIC_EUCLID;
		end else if (cfg_valid && cfg_ready) begin
			metric_kind_q <= vmd_pkg::metric_t'(cfg_data);
		end
	end

	vmd_front #(
		.CNT_W (CNT_W),
		.DEPTH (QDEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.x_elem      (x_elem),
		.y_elem      (y_elem),
		.last        (last),
		.metric_kind (metric_kind_q),
		.q_count     (q_count),
		.q_push      (q_push),
		.q_entry     (q_wr_entry)
	);

	vmd_queue #(
		.DEPTH (QDEPTH),
		.CNT_W (CNT_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.pop      (q_pop),
		.rd_entry (q_rd_entry),
		.count    (q_count)
	);

	vmd_back #(
		.CNT_W (CNT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_count   (q_count),
		.q_entry   (q_rd_entry),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.distance  (distance)
	);

	`VMD_ASSERT_SAME(a_push_room, q_push, q_count != CNT_W'(QDEPTH), "push into full queue")
	`VMD_ASSERT_SAME(a_pop_nonempty, q_pop, q_count != '0, "pop from empty queue")
	`VMD_ASSERT_SAME(a_count_bound, 1'b1, q_count <= CNT_W'(QDEPTH), "queue count beyond depth")
	`VMD_ASSERT_SAME(a_full_stalls, q_count == CNT_W'(QDEPTH), in_stall, "input open with full queue")

endmodule

@@ rtl/core/vmd_front.sv @@
// front end: accepts element pairs, forms |x-y| and, for euclidean, its square, folds into the accumulator
// depends on vmd_pkg; pushes finished vectors into vmd_queue
module vmd_front #(
	parameter int CNT_W = 3,
	parameter int DEPTH = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [vmd_pkg::ELEM_W-1:0] x_elem,
	input  logic signed [vmd_pkg::ELEM_W-1:0] y_elem,
	input  logic                      last,
	input  vmd_pkg::metric_t          metric_kind,
	input  logic [CNT_W-1:0]          q_count,
	output logic                      q_push,
	output vmd_pkg::vmd_entry_t       q_entry
);

	localparam int OCC_W = CNT_W + 2;

	logic                          valid_s1, last_s1;
	logic [vmd_pkg::ABS_W-1:0]     ad_s1;
	vmd_pkg::metric_t              mode_s1;
	logic                          valid_s2, last_s2;
	logic [vmd_pkg::TERM_W-1:0]    term_s2;
	vmd_pkg::metric_t              mode_s2;
	logic [vmd_pkg::ACC_W-1:0]     acc_q;

	logic                          accept;
	logic signed [vmd_pkg::ELEM_W:0] diff;
	logic [vmd_pkg::ELEM_W:0]      diff_abs;
	logic [OCC_W-1:0]              occ;
	logic [vmd_pkg::ACC_W:0]       sum;
	logic [vmd_pkg::ACC_W-1:0]     sum_sat, term_ext, acc_next;

	// reserve a queue slot for every last item still in flight
	assign occ = OCC_W'(q_count) + OCC_W'(valid_s1 & last_s1) + OCC_W'(valid_s2 & last_s2);
	assign in_stall = (occ >= OCC_W'(DEPTH));
	assign accept = in_valid & ~in_stall;

	assign diff     = {x_elem[vmd_pkg::ELEM_W-1], x_elem} - {y_elem[vmd_pkg::ELEM_W-1], y_elem};
	assign diff_abs = diff[vmd_pkg::ELEM_W] ? (~diff + 1'b1) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ad_s1   <= diff_abs[vmd_pkg::ABS_W-1:0];
			mode_s1 <= metric_kind;
			last_s1 <= last;
		end
		if (valid_s1) begin
			term_s2 <= (mode_s1 == vmd_pkg::METRIC_EUCLID) ? ad_s1 * ad_s1
			                                                : vmd_pkg::TERM_W'(ad_s1);
			mode_s2 <= mode_s1;
			last_s2 <= last_s1;
		end
	end

	assign term_ext = vmd_pkg::ACC_W'(term_s2);
	assign sum      = {1'b0, acc_q} + {1'b0, term_ext};
	assign sum_sat  = sum[vmd_pkg::ACC_W] ? {vmd_pkg::ACC_W{1'b1}} : sum[vmd_pkg::ACC_W-1:0];

	always_comb begin
		case (mode_s2) inside
			vmd_pkg::METRIC_EUCLID, vmd_pkg::METRIC_MANHAT: acc_next = sum_sat;
			vmd_pkg::METRIC_CHEBY: acc_next = (term_ext > acc_q) ? term_ext : acc_q;
			default: acc_next = acc_q | vmd_pkg::ACC_W'(term_s2 != '0);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= last_s2 ? '0 : acc_next;
		end
	end

	assign q_push        = valid_s2 & last_s2;
	assign q_entry.acc   = acc_next;
	assign q_entry.mode  = mode_s2;

endmodule

@@ rtl/core/vmd_queue.sv @@
// small queue of finished vector accumulators between front and back
// depends on vmd_pkg
module vmd_queue #(
	parameter int DEPTH = 4,
	parameter int CNT_W = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  vmd_pkg::vmd_entry_t wr_entry,
	input  logic                pop,
	output vmd_pkg::vmd_entry_t rd_entry,
	output logic [CNT_W-1:0]    count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	vmd_pkg::vmd_entry_t mem [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	assign rd_entry = mem[rd_ptr_q];
	assign count    = count_q;

endmodule

@@ rtl/core/vmd_isqrt.sv @@
// iterative integer square root, one result bit per cycle
// depends on vmd_pkg
module vmd_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [vmd_pkg::ACC_W-1:0]   radicand,
	output vmd_pkg::vmd_sqrt_stat_t     stat,
	output logic [vmd_pkg::ROOT_W-1:0]  root
);

	logic [vmd_pkg::RAD_W-1:0]  rad_q;
	logic [vmd_pkg::REM_W-1:0]  rem_q;
	logic [vmd_pkg::ROOT_W-1:0] root_q;
	logic [vmd_pkg::STEP_W-1:0] step_q;
	logic                       busy_q, done_q;

	logic [vmd_pkg::REM_W-1:0]  rem_sh, trial;
	logic                       fits;

	// bring down the next two radicand bits and try root*4+1
	assign rem_sh = {rem_q[vmd_pkg::REM_W-3:0], rad_q[vmd_pkg::RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == vmd_pkg::STEP_W'(vmd_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= vmd_pkg::RAD_W'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[vmd_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[vmd_pkg::ROOT_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

@@ rtl/core/vmd_back.sv @@
// back end: pops finished vectors, forms the distance, holds it in the output register
// depends on vmd_pkg and vmd_isqrt
module vmd_back #(
	parameter int CNT_W = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [CNT_W-1:0]           q_count,
	input  vmd_pkg::vmd_entry_t        q_entry,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [vmd_pkg::DIST_W-1:0] distance
);

	vmd_pkg::back_state_t      state_q, state_d;
	logic                      out_valid_q;
	logic [vmd_pkg::DIST_W-1:0] distance_q;

	vmd_pkg::vmd_sqrt_stat_t    sq_stat;
	logic [vmd_pkg::ROOT_W-1:0] sq_root;

	logic out_free, can_pop, is_euclid;
	logic sq_start, load_direct, load_root;
	logic [vmd_pkg::DIST_W-1:0] direct_val;

	assign out_free  = ~out_valid_q | ~out_stall;
	assign can_pop   = (q_count != '0) & out_free;
	assign is_euclid = (q_entry.mode == vmd_pkg::METRIC_EUCLID);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vmd_pkg::BK_IDLE: begin
				if (can_pop && is_euclid) state_d = vmd_pkg::BK_SQRT;
			end
			vmd_pkg::BK_SQRT: begin
				if (sq_stat.done) state_d = vmd_pkg::BK_IDLE;
			end
			default: state_d = vmd_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop       = 1'b0;
		sq_start    = 1'b0;
		load_direct = 1'b0;
		load_root   = 1'b0;
		unique case (state_q)
			vmd_pkg::BK_IDLE: begin
				q_pop       = can_pop;
				sq_start    = can_pop & is_euclid;
				load_direct = can_pop & ~is_euclid;
			end
			vmd_pkg::BK_SQRT: begin
				load_root = sq_stat.done;
			end
			default: ;
		endcase
	end

	always_comb begin
		case (q_entry.mode)
			vmd_pkg::METRIC_DISCR: direct_val = vmd_pkg::DIST_W'(q_entry.acc != '0);
			default: begin
				direct_val = (q_entry.acc[vmd_pkg::ACC_W-1:vmd_pkg::DIST_W] != '0)
				             ? {vmd_pkg::DIST_W{1'b1}} : q_entry.acc[vmd_pkg::DIST_W-1:0];
			end
		endcase
	end

	vmd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (q_entry.acc),
		.stat     (sq_stat),
		.root     (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vmd_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_direct || load_root) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			distance_q <= direct_val;
		end else if (load_root) begin
			distance_q <= vmd_pkg::DIST_W'(sq_root);
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = distance_q;

endmodule
